// ===== rtl/core/wevs_pkg.sv =====
`timescale 1ns / 1ps
package wevs_pkg;

    localparam int ID_W       = 16;
    localparam int IDLE_W     = 32;
    localparam int SIZE_W     = 40;
    localparam int SCORE_W    = 32;
    localparam int WGT_W      = 16;
    localparam int FRAC_W     = 17;
    localparam int DIV_STEP_W = 5;
    localparam int LIM_W      = 6;
    localparam int FLAG_W     = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int RESULT_CAP = 32;

    localparam logic [SCORE_W-1:0] ACTIVE_SCORE = 32'd655360;

    // flag bit positions inside a stored record
    localparam int F_ACTIVE  = 0;
    localparam int F_AUDIO   = 1;
    localparam int F_SESSION = 2;
    localparam int F_PINNED  = 3;
    localparam int F_UNSAVED = 4;
    localparam int F_DROPPED = 5;

    localparam logic [1:0] LVL_CRITICAL  = 2'd2;
    localparam logic [1:0] LVL_EMERGENCY = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RECENCY_WEIGHT   = 3'd0,
        REG_SIZE_WEIGHT      = 3'd1,
        REG_PIN_BONUS        = 3'd2,
        REG_MEDIA_BONUS      = 3'd3,
        REG_GRACE_SECONDS    = 3'd4,
        REG_CRITICAL_LIMIT   = 3'd5,
        REG_KEEP_ALIVE_COUNT = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [ID_W-1:0]   entry_id;
        logic [IDLE_W-1:0] idle_seconds;
        logic [SIZE_W-1:0] size_bytes;
        logic              entry_active;
        logic              plays_audio;
        logic              has_session;
        logic              entry_pinned;
        logic              has_unsaved;
        logic              already_dropped;
        logic [1:0]        pressure_level;
        logic              last_entry;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0] victim_id;
        logic            victim_valid;
        logic            last_victim;
    } out_item_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [IDLE_W-1:0] idle;
        logic [SIZE_W-1:0] size;
        logic [FLAG_W-1:0] flags;
    } rec_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [ID_W-1:0]    id;
    } rank_t;

    typedef struct packed {
        logic clear;
        logic ins;
        logic pop;
    } rank_ctl_t;

endpackage

// ===== rtl/core/wevs_div.sv =====
`timescale 1ns / 1ps
module wevs_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [wevs_pkg::SIZE_W-1:0]     dividend,
    input  logic [wevs_pkg::SIZE_W-1:0]     divisor,
    output logic                            busy,
    output logic                            done,
    output logic [wevs_pkg::FRAC_W-1:0]     quotient
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [wevs_pkg::DIV_STEP_W-1:0]   step_reg;
    logic [wevs_pkg::SIZE_W:0]         rem_reg;
    logic [wevs_pkg::SIZE_W-1:0]       div_reg;
    logic [wevs_pkg::FRAC_W-1:0]       quo_reg;
    logic [wevs_pkg::SIZE_W:0]         trial;
    logic                              ge;
    logic [wevs_pkg::SIZE_W-1:0]       rest;

    // clamp: a value above the largest gives a zero fraction
    assign rest  = (dividend <= divisor) ? (divisor - dividend) : '0;
    assign trial = (step_reg == '0) ? rem_reg : {rem_reg[wevs_pkg::SIZE_W-1:0], 1'b0};
    assign ge    = (trial >= {1'b0, div_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= !start && busy_reg &&
                        (step_reg == wevs_pkg::DIV_STEP_W'(wevs_pkg::FRAC_W - 1));
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + wevs_pkg::DIV_STEP_W'(1);
                if (step_reg == wevs_pkg::DIV_STEP_W'(wevs_pkg::FRAC_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= {1'b0, rest};
            div_reg <= divisor;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? (trial - {1'b0, div_reg}) : trial;
            quo_reg <= {quo_reg[wevs_pkg::FRAC_W-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/wevs_rank_cell.sv =====
`timescale 1ns / 1ps
module wevs_rank_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  wevs_pkg::rank_ctl_t ctl,
    input  wevs_pkg::rank_t     new_item,
    input  wevs_pkg::rank_t     prev_item,
    input  logic                prev_valid,
    input  logic                prev_keep,
    input  wevs_pkg::rank_t     next_item,
    input  logic                next_valid,
    output wevs_pkg::rank_t     item,
    output logic                valid,
    output logic                keep
);

    wevs_pkg::rank_t item_reg;
    logic            valid_reg;

    // equal scores stay ahead of the newcomer to keep load order
    assign keep = valid_reg && (item_reg.score <= new_item.score);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl.clear) begin
            valid_reg <= 1'b0;
        end else if (ctl.ins && !keep) begin
            valid_reg <= prev_keep ? 1'b1 : prev_valid;
        end else if (ctl.pop) begin
            valid_reg <= next_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ins && !keep) begin
            item_reg <= prev_keep ? new_item : prev_item;
        end else if (ctl.pop) begin
            item_reg <= next_item;
        end
    end

    assign item  = item_reg;
    assign valid = valid_reg;

endmodule

// ===== rtl/core/weighted_eviction_victim_select.sv =====
`timescale 1ns / 1ps
// channel   | ports                      | payload
// ----------+----------------------------+-------------------------------
// input     | s_valid, s_ready, s_data   | wevs_pkg::in_item_t (one record)
// result    | m_valid, m_ready, m_data   | wevs_pkg::out_item_t (one victim)
// config    | cfg_we, cfg_index, cfg_wdata | registers 0..6, no read-back
//
// Records load one per cycle into a shift line. After the last record the line
// shifts until the oldest stored record reaches the last tap; then each stored
// record takes two 17-step divisions in one shared divider, two multiplies, a
// sum and, if eligible, one insertion into the sorted chain of rank cells. Victims
// then leave one per cycle from the chain head while m_ready is high. Reset is
// synchronous, active low; no clearing pass. s_ready is low from the last record
// until the final result is registered.
module weighted_eviction_victim_select #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  wevs_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output wevs_pkg::out_item_t               m_data,
    input  logic                              cfg_we,
    input  logic [wevs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wevs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int EW    = 8;

    typedef enum logic [3:0] {
        S_LOAD, S_ALIGN, S_RSTART, S_RWAIT, S_SSTART, S_SWAIT,
        S_SCORE, S_INSERT, S_EMIT
    } state_t;

    state_t                           state_reg;
    logic [wevs_pkg::WGT_W-1:0]       rw_reg, sw_reg, pin_reg, media_reg;
    logic [wevs_pkg::IDLE_W-1:0]      grace_reg;
    logic [wevs_pkg::LIM_W-1:0]       crit_reg, keep_reg;

    logic [CNT_W-1:0]                 count_reg, align_reg, proc_reg, elig_cnt_reg, emit_reg;
    logic [wevs_pkg::IDLE_W-1:0]      lidle_reg;
    logic [wevs_pkg::SIZE_W-1:0]      lsize_reg;
    logic [1:0]                       level_reg;
    logic [EW-1:0]                    limit_reg;
    logic [wevs_pkg::SCORE_W-1:0]     rterm_reg, sterm_reg;
    wevs_pkg::rank_t                  score_reg;
    logic                             elig_reg;
    logic                             m_valid_reg;
    wevs_pkg::out_item_t              m_data_reg;

    wevs_pkg::rec_t                   rec_reg [MAX_ENTRIES];
    wevs_pkg::rec_t                   head;
    wevs_pkg::rec_t                   in_rec;

    logic                             s_acc, store, rec_shift;
    logic                             div_start, div_busy, div_done;
    logic [wevs_pkg::SIZE_W-1:0]      div_a, div_b;
    logic [wevs_pkg::FRAC_W-1:0]      div_q;
    logic [wevs_pkg::WGT_W-1:0]       wsel;
    logic [wevs_pkg::FRAC_W+wevs_pkg::WGT_W-1:0] prod;
    logic [wevs_pkg::SCORE_W-1:0]     term, sum;
    logic                             elig_now;
    logic [EW-1:0]                    n8, keep8, em8, raw8, k8;
    logic                             can_out, last_out;

    wevs_pkg::rank_ctl_t              ctl;
    wevs_pkg::rank_t                  rank_item [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]           rank_valid, rank_keep;

    assign s_ready = (state_reg == S_LOAD);
    assign s_acc   = s_valid && s_ready;
    assign store   = (count_reg < CNT_W'(MAX_ENTRIES));
    assign head    = rec_reg[MAX_ENTRIES-1];

    assign in_rec.id    = s_data.entry_id;
    assign in_rec.idle  = s_data.idle_seconds;
    assign in_rec.size  = s_data.size_bytes;
    assign in_rec.flags = {s_data.already_dropped, s_data.has_unsaved, s_data.entry_pinned,
                           s_data.has_session, s_data.plays_audio, s_data.entry_active};

    assign rec_shift = (s_acc && store) ||
                       (state_reg == S_ALIGN && align_reg != CNT_W'(MAX_ENTRIES)) ||
                       (state_reg == S_INSERT);

    // shift line: oldest record reaches the last tap after alignment
    always_ff @(posedge aclk) begin
        if (rec_shift) begin
            rec_reg[0] <= in_rec;
            for (int i = 1; i < MAX_ENTRIES; i++) begin
                rec_reg[i] <= rec_reg[i-1];
            end
        end
    end

    assign div_start = (state_reg == S_RSTART) || (state_reg == S_SSTART);
    assign div_a = (state_reg == S_RSTART) ? wevs_pkg::SIZE_W'(head.idle) : head.size;
    assign div_b = (state_reg == S_RSTART) ? wevs_pkg::SIZE_W'(lidle_reg) : lsize_reg;

    wevs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign wsel = (state_reg == S_RWAIT) ? rw_reg : sw_reg;
    assign prod = (wevs_pkg::FRAC_W+wevs_pkg::WGT_W)'(div_q) *
                  (wevs_pkg::FRAC_W+wevs_pkg::WGT_W)'(wsel);
    assign term = wevs_pkg::SCORE_W'(prod >> 8);

    always_comb begin
        sum = rterm_reg + sterm_reg;
        if (head.flags[wevs_pkg::F_PINNED])  sum = sum + {8'b0, pin_reg, 8'b0};
        if (head.flags[wevs_pkg::F_AUDIO])   sum = sum + {8'b0, media_reg, 8'b0};
        if (head.flags[wevs_pkg::F_SESSION]) sum = sum + {8'b0, media_reg, 8'b0};
        if (head.flags[wevs_pkg::F_UNSAVED]) sum = sum + {8'b0, pin_reg, 8'b0};
    end

    assign elig_now = !head.flags[wevs_pkg::F_ACTIVE] && !head.flags[wevs_pkg::F_AUDIO] &&
                      !head.flags[wevs_pkg::F_SESSION] && !head.flags[wevs_pkg::F_UNSAVED] &&
                      !head.flags[wevs_pkg::F_DROPPED] && (head.idle >= grace_reg);

    assign n8    = EW'(count_reg);
    assign keep8 = EW'(keep_reg);
    assign em8   = (n8 > keep8) ? (n8 - keep8) : '0;
    always_comb begin
        if (level_reg == wevs_pkg::LVL_EMERGENCY) begin
            raw8 = em8;
        end else if (level_reg == wevs_pkg::LVL_CRITICAL) begin
            raw8 = EW'(crit_reg);
        end else begin
            raw8 = '0;
        end
    end

    assign k8       = (limit_reg < EW'(elig_cnt_reg)) ? limit_reg : EW'(elig_cnt_reg);
    assign can_out  = (state_reg == S_EMIT) && (!m_valid_reg || m_ready);
    assign last_out = (EW'(emit_reg) + EW'(1) == k8);

    assign ctl.clear = (state_reg == S_ALIGN);
    assign ctl.ins   = (state_reg == S_INSERT) && elig_reg;
    assign ctl.pop   = can_out && (k8 != '0);

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_rank
        if (g == 0) begin : g_first
            wevs_rank_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctl        (ctl),
                .new_item   (score_reg),
                .prev_item  (score_reg),
                .prev_valid (1'b0),
                .prev_keep  (1'b1),
                .next_item  (rank_item[(g+1) % MAX_ENTRIES]),
                .next_valid (rank_valid[(g+1) % MAX_ENTRIES]),
                .item       (rank_item[g]),
                .valid      (rank_valid[g]),
                .keep       (rank_keep[g])
            );
        end else if (g == MAX_ENTRIES - 1) begin : g_last
            wevs_rank_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctl        (ctl),
                .new_item   (score_reg),
                .prev_item  (rank_item[g-1]),
                .prev_valid (rank_valid[g-1]),
                .prev_keep  (rank_keep[g-1]),
                .next_item  (score_reg),
                .next_valid (1'b0),
                .item       (rank_item[g]),
                .valid      (rank_valid[g]),
                .keep       (rank_keep[g])
            );
        end else begin : g_mid
            wevs_rank_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctl        (ctl),
                .new_item   (score_reg),
                .prev_item  (rank_item[g-1]),
                .prev_valid (rank_valid[g-1]),
                .prev_keep  (rank_keep[g-1]),
                .next_item  (rank_item[g+1]),
                .next_valid (rank_valid[g+1]),
                .item       (rank_item[g]),
                .valid      (rank_valid[g]),
                .keep       (rank_keep[g])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rw_reg    <= 16'd256;
            sw_reg    <= 16'd256;
            pin_reg   <= 16'd512;
            media_reg <= 16'd1280;
            grace_reg <= 32'd300;
            crit_reg  <= 6'd1;
            keep_reg  <= 6'd3;
        end else if (cfg_we) begin
            unique case (wevs_pkg::cfg_reg_t'(cfg_index))
                wevs_pkg::REG_RECENCY_WEIGHT:   rw_reg    <= cfg_wdata[wevs_pkg::WGT_W-1:0];
                wevs_pkg::REG_SIZE_WEIGHT:      sw_reg    <= cfg_wdata[wevs_pkg::WGT_W-1:0];
                wevs_pkg::REG_PIN_BONUS:        pin_reg   <= cfg_wdata[wevs_pkg::WGT_W-1:0];
                wevs_pkg::REG_MEDIA_BONUS:      media_reg <= cfg_wdata[wevs_pkg::WGT_W-1:0];
                wevs_pkg::REG_GRACE_SECONDS:    grace_reg <= cfg_wdata[wevs_pkg::IDLE_W-1:0];
                wevs_pkg::REG_CRITICAL_LIMIT:   crit_reg  <= cfg_wdata[wevs_pkg::LIM_W-1:0];
                wevs_pkg::REG_KEEP_ALIVE_COUNT: keep_reg  <= cfg_wdata[wevs_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_LOAD;
            count_reg    <= '0;
            lidle_reg    <= '0;
            lsize_reg    <= wevs_pkg::SIZE_W'(1);
            m_valid_reg  <= 1'b0;
            align_reg    <= '0;
            proc_reg     <= '0;
            elig_cnt_reg <= '0;
            emit_reg     <= '0;
            level_reg    <= '0;
            limit_reg    <= '0;
        end else begin
            if (m_valid_reg && m_ready && !can_out) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_LOAD: begin
                    if (s_acc) begin
                        if (store) begin
                            count_reg <= count_reg + CNT_W'(1);
                            if (!s_data.entry_active && s_data.idle_seconds > lidle_reg) begin
                                lidle_reg <= s_data.idle_seconds;
                            end
                            if (s_data.size_bytes > lsize_reg) begin
                                lsize_reg <= s_data.size_bytes;
                            end
                        end
                        if (s_data.last_entry) begin
                            level_reg <= s_data.pressure_level;
                            align_reg <= store ? count_reg + CNT_W'(1) : count_reg;
                            state_reg <= S_ALIGN;
                        end
                    end
                end
                S_ALIGN: begin
                    limit_reg <= (raw8 > EW'(wevs_pkg::RESULT_CAP)) ?
                                 EW'(wevs_pkg::RESULT_CAP) : raw8;
                    if (align_reg == CNT_W'(MAX_ENTRIES)) begin
                        proc_reg     <= '0;
                        elig_cnt_reg <= '0;
                        state_reg    <= S_RSTART;
                    end else begin
                        align_reg <= align_reg + CNT_W'(1);
                    end
                end
                S_RSTART: state_reg <= S_RWAIT;
                S_RWAIT: begin
                    if (div_done) begin
                        rterm_reg <= (lidle_reg == '0) ? '0 : term;
                        state_reg <= S_SSTART;
                    end
                end
                S_SSTART: state_reg <= S_SWAIT;
                S_SWAIT: begin
                    if (div_done) begin
                        sterm_reg <= term;
                        state_reg <= S_SCORE;
                    end
                end
                S_SCORE: begin
                    score_reg.score <= head.flags[wevs_pkg::F_ACTIVE] ?
                                       wevs_pkg::ACTIVE_SCORE : sum;
                    score_reg.id    <= head.id;
                    elig_reg        <= elig_now;
                    state_reg       <= S_INSERT;
                end
                S_INSERT: begin
                    proc_reg     <= proc_reg + CNT_W'(1);
                    elig_cnt_reg <= elig_cnt_reg + CNT_W'(elig_reg);
                    if (proc_reg + CNT_W'(1) == count_reg) begin
                        emit_reg  <= '0;
                        state_reg <= S_EMIT;
                    end else begin
                        state_reg <= S_RSTART;
                    end
                end
                S_EMIT: begin
                    if (can_out) begin
                        m_valid_reg <= 1'b1;
                        if (k8 == '0) begin
                            m_data_reg.victim_id    <= '0;
                            m_data_reg.victim_valid <= 1'b0;
                            m_data_reg.last_victim  <= 1'b1;
                        end else begin
                            m_data_reg.victim_id    <= rank_item[0].id;
                            m_data_reg.victim_valid <= 1'b1;
                            m_data_reg.last_victim  <= last_out;
                            emit_reg                <= emit_reg + CNT_W'(1);
                        end
                        // drop the load once the final result is out
                        if (k8 == '0 || last_out) begin
                            count_reg <= '0;
                            lidle_reg <= '0;
                            lsize_reg <= wevs_pkg::SIZE_W'(1);
                            state_reg <= S_LOAD;
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.victim_valid) |-> m_data.last_victim)
        else $error("empty result not marked last");

    a_rank_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        !rank_valid[0] |-> (rank_valid == '0))
        else $error("rank chain has a hole at its head");
`endif

endmodule
